>>> hw/rtl/tbrl_pkg.sv
// Package for the token bucket rate limiter: payload and storage types,
// register codes, reset values and shared constants.
// No dependencies; imported by the front end, the update engine and the top level.
package tbrl_pkg;

   // Field widths fixed by the interface
   localparam int KEY_W   = 10;
   localparam int TIME_W  = 32;
   localparam int TOKEN_W = 32;
   localparam int CAP_W   = 16;
   localparam int RATE_W  = 32;
   localparam int FRAC_W  = 16;

   // Default number of buckets
   localparam int NUM_KEYS_DEFAULT = 1024;

   // Entries of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPACITY    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REFILL_RATE = 2'd1;

   localparam logic [CAP_W-1:0]  CAPACITY_RESET    = 16'd10;
   localparam logic [RATE_W-1:0] REFILL_RATE_RESET = 32'h0001_0000;

   // One whole token in Q16.16
   localparam logic [TOKEN_W-1:0] ONE_TOKEN = 32'h0001_0000;

   typedef struct packed {
      logic [KEY_W-1:0]  key_index;
      logic [TIME_W-1:0] now_seconds;
   } req_payload_type;

   typedef struct packed {
      logic             allowed;
      logic [CAP_W-1:0] remaining;
   } rsp_payload_type;

   // One word of the bucket store
   typedef struct packed {
      logic               valid;
      logic [TIME_W-1:0]  last_time;
      logic [TOKEN_W-1:0] tokens;
   } bucket_entry_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CALC,
      ST_UPDATE
   } back_state_type;

   // Address width for a store of n entries (at least one bit)
   function automatic int idx_width(input int n);
      int w;
      w = (n > 1) ? $clog2(n) : 1;
      return w;
   endfunction

endpackage

>>> hw/rtl/tbrl_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; used for the bucket store.
module tbrl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/tbrl_front.sv
// Front end: takes request transfers and reduces the key to a bucket index.
// Depends on tbrl_pkg; feeds tbrl_queue.
module tbrl_front #(
   parameter int NUM_KEYS = tbrl_pkg::NUM_KEYS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  tbrl_pkg::req_payload_type  req_payload,
   input  logic                       clearing,
   output logic                       push_valid,
   output logic [tbrl_pkg::idx_width(NUM_KEYS)+tbrl_pkg::TIME_W-1:0] push_data,
   input  logic                       push_full
);
   import tbrl_pkg::*;

   localparam int IDX_W = idx_width(NUM_KEYS);
   // Reciprocal of the key count for the modulo estimate
   localparam logic [20:0] RECIP  = 21'((1 << 20) / NUM_KEYS);
   localparam logic [16:0] KEYS_C = 17'(NUM_KEYS);

   logic              a_valid_ff, a_valid_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [KEY_W-1:0]  q_est_ff, q_est_in;

   logic        accept;
   logic        advance;
   logic [29:0] q_prod;
   logic [26:0] q_times_n;
   logic [26:0] rem_raw;
   logic [26:0] rem_fix;

   // Hold the stage while the queue is full; take no request during the clearing pass
   assign advance   = a_valid_ff && !push_full;
   assign req_stall = clearing || (a_valid_ff && push_full);
   assign accept    = req_valid && !req_stall;

   // Quotient estimate, at most one below the true quotient
   assign q_prod   = 30'(req_payload.key_index) * 30'(RECIP);
   assign q_est_in = accept ? q_prod[29:20] : q_est_ff;

   assign key_in     = accept ? req_payload.key_index   : key_ff;
   assign now_in     = accept ? req_payload.now_seconds : now_ff;
   assign a_valid_in = accept ? 1'b1 : (advance ? 1'b0 : a_valid_ff);

   // Remainder with a single correction step
   assign q_times_n = 27'(q_est_ff) * 27'(KEYS_C);
   assign rem_raw   = 27'(key_ff) - q_times_n;
   assign rem_fix   = (rem_raw >= 27'(KEYS_C)) ? (rem_raw - 27'(KEYS_C)) : rem_raw;

   assign push_valid = a_valid_ff;
   assign push_data  = {rem_fix[IDX_W-1:0], now_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      now_ff   <= now_in;
      q_est_ff <= q_est_in;
   end

endmodule

>>> hw/rtl/tbrl_queue.sv
// Short FIFO that decouples the front end from the bucket update engine.
// Depends on nothing; sits between tbrl_front and tbrl_back.
module tbrl_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic do_push;
   logic do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];

   assign do_push = push_valid && !full;
   assign do_pop  = pop && head_valid;

   // Pointer and occupancy update with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hw/rtl/tbrl_back.sv
// Bucket update engine: clears the store after reset, then reads, refills,
// charges and writes back one bucket per request. Depends on tbrl_pkg, tbrl_ram.
module tbrl_back #(
   parameter int NUM_KEYS = tbrl_pkg::NUM_KEYS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [tbrl_pkg::CAP_W-1:0]  capacity,
   input  logic [tbrl_pkg::RATE_W-1:0] refill_rate,
   input  logic                      job_valid,
   input  logic [tbrl_pkg::idx_width(NUM_KEYS)+tbrl_pkg::TIME_W-1:0] job_data,
   output logic                      job_pop,
   output logic                      clearing,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output tbrl_pkg::rsp_payload_type rsp_payload
);
   import tbrl_pkg::*;

   localparam int IDX_W   = idx_width(NUM_KEYS);
   localparam int ENTRY_W = $bits(bucket_entry_type);

   back_state_type    state_ff, state_in;
   logic [IDX_W-1:0]  clear_addr_ff, clear_addr_in;
   logic [IDX_W-1:0]  job_idx_ff, job_idx_in;
   logic [TIME_W-1:0] job_now_ff, job_now_in;
   logic [TOKEN_W-1:0] tokens_ff, tokens_in;
   logic [TOKEN_W-1:0] refill_ff, refill_in;
   logic [TOKEN_W-1:0] cap_ff, cap_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_payload_ff, rsp_payload_in;

   // Control produced by the output decoder
   logic             ram_we;
   logic [IDX_W-1:0] ram_wr_addr;
   bucket_entry_type ram_wr_data;
   logic             ram_re;
   logic             calc_load;
   logic             rsp_load;

   bucket_entry_type rd_entry;
   logic [ENTRY_W-1:0] rd_word;
   logic             out_free;

   logic [TOKEN_W-1:0] cap_word;
   logic [TOKEN_W-1:0] base_tokens;
   logic [TIME_W-1:0]  elapsed;
   logic [63:0]        product;
   logic [TOKEN_W-1:0] refill_sat;
   logic [TOKEN_W:0]   sum;
   logic [TOKEN_W-1:0] capped;
   logic               allow;
   logic [TOKEN_W-1:0] left_tokens;
   bucket_entry_type   new_entry;

   tbrl_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_KEYS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_re),
      .rd_addr (job_data[IDX_W+TIME_W-1:TIME_W]),
      .rd_data (rd_word)
   );

   assign rd_entry = bucket_entry_type'(rd_word);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Refill: an unseen bucket starts full at the current time
   assign cap_word    = {capacity, {FRAC_W{1'b0}}};
   assign base_tokens = rd_entry.valid ? rd_entry.tokens : cap_word;
   assign elapsed     = (rd_entry.valid && (job_now_ff > rd_entry.last_time)) ?
                        (job_now_ff - rd_entry.last_time) : '0;
   assign product     = 64'(elapsed) * 64'(refill_rate);
   assign refill_sat  = (|product[63:32]) ? '1 : product[31:0];

   // Cap at capacity, then take one token if there is one
   assign sum         = {1'b0, tokens_ff} + {1'b0, refill_ff};
   assign capped      = (sum > {1'b0, cap_ff}) ? cap_ff : sum[TOKEN_W-1:0];
   assign allow       = |capped[TOKEN_W-1:FRAC_W];
   assign left_tokens = allow ? (capped - ONE_TOKEN) : capped;

   always_comb begin
      new_entry.valid     = 1'b1;
      new_entry.last_time = job_now_ff;
      new_entry.tokens    = left_tokens;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clear_addr_ff == IDX_W'(NUM_KEYS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (job_valid) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output decoder
   always_comb begin
      ram_we      = 1'b0;
      ram_wr_addr = job_idx_ff;
      ram_wr_data = new_entry;
      ram_re      = 1'b0;
      job_pop     = 1'b0;
      calc_load   = 1'b0;
      rsp_load    = 1'b0;
      clearing    = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            clearing    = 1'b1;
            ram_we      = 1'b1;
            ram_wr_addr = clear_addr_ff;
            ram_wr_data = '0;
         end
         ST_IDLE: begin
            ram_re  = job_valid;
            job_pop = job_valid;
         end
         ST_CALC: begin
            calc_load = 1'b1;
         end
         ST_UPDATE: begin
            ram_we   = out_free;
            rsp_load = out_free;
         end
         default: begin
            clearing = 1'b0;
         end
      endcase
   end

   // Data path register inputs
   assign clear_addr_in = clearing ? clear_addr_ff + IDX_W'(1) : clear_addr_ff;
   assign job_idx_in    = job_pop ? job_data[IDX_W+TIME_W-1:TIME_W] : job_idx_ff;
   assign job_now_in    = job_pop ? job_data[TIME_W-1:0] : job_now_ff;
   assign tokens_in     = calc_load ? base_tokens : tokens_ff;
   assign refill_in     = calc_load ? refill_sat : refill_ff;
   assign cap_in        = calc_load ? cap_word : cap_ff;

   // Result register: loads when the slot is empty or being emptied
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (rsp_load) begin
         rsp_valid_in             = 1'b1;
         rsp_payload_in.allowed   = allow;
         rsp_payload_in.remaining = allow ? left_tokens[TOKEN_W-1:FRAC_W] : '0;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_idx_ff     <= job_idx_in;
      job_now_ff     <= job_now_in;
      tokens_ff      <= tokens_in;
      refill_ff      <= refill_in;
      cap_ff         <= cap_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

>>> hw/rtl/token_bucket_rate_limiter_unit.sv
// Top level of the per-key token bucket rate limiter: configuration registers,
// front end, queue and bucket update engine. Depends on tbrl_pkg and submodules.
//
//   Port group | Direction | Transfer when            | Payload
//   req_       | in        | req_valid && !req_stall  | key_index, now_seconds
//   rsp_       | out       | rsp_valid && !rsp_stall  | allowed, remaining
//   csr_       | in        | csr_we                   | csr_index, csr_wdata
//
// Each request takes a store read, a refill multiply, and an update with
// write-back in the update engine, which pops the next request only after
// that write-back. A request passes the front-end register, the queue, the
// store read and refill registers on its way to the result register.
// After reset the store is cleared entry by entry, with req_stall high.
// A stalled result holds the engine; the queue keeps taking requests until full.
module token_bucket_rate_limiter_unit #(
   parameter int NUM_KEYS = tbrl_pkg::NUM_KEYS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  tbrl_pkg::req_payload_type        req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output tbrl_pkg::rsp_payload_type        rsp_payload,
   input  logic                             csr_we,
   input  logic [tbrl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tbrl_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tbrl_pkg::*;

   localparam int IDX_W = idx_width(NUM_KEYS);
   localparam int JOB_W = IDX_W + TIME_W;

   logic [CAP_W-1:0]  capacity_ff, capacity_in;
   logic [RATE_W-1:0] refill_rate_ff, refill_rate_in;

   logic             clearing;
   logic             push_valid;
   logic [JOB_W-1:0] push_data;
   logic             push_full;
   logic             job_pop;
   logic             job_valid;
   logic [JOB_W-1:0] job_data;

   // Configuration writes; unknown indexes are ignored
   always_comb begin
      capacity_in    = capacity_ff;
      refill_rate_in = refill_rate_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CAPACITY:    capacity_in    = csr_wdata[CAP_W-1:0];
            CSR_REFILL_RATE: refill_rate_in = csr_wdata[RATE_W-1:0];
            default:         capacity_in    = capacity_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff    <= CAPACITY_RESET;
         refill_rate_ff <= REFILL_RATE_RESET;
      end else begin
         capacity_ff    <= capacity_in;
         refill_rate_ff <= refill_rate_in;
      end
   end

   tbrl_front #(
      .NUM_KEYS (NUM_KEYS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .clearing    (clearing),
      .push_valid  (push_valid),
      .push_data   (push_data),
      .push_full   (push_full)
   );

   tbrl_queue #(
      .WIDTH (JOB_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (push_full),
      .pop        (job_pop),
      .head_valid (job_valid),
      .head_data  (job_data)
   );

   tbrl_back #(
      .NUM_KEYS (NUM_KEYS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .capacity    (capacity_ff),
      .refill_rate (refill_rate_ff),
      .job_valid   (job_valid),
      .job_data    (job_data),
      .job_pop     (job_pop),
      .clearing    (clearing),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> hw/rtl/tbrl_checker.sv
// Port-level checks for the token bucket rate limiter, bound to the top level.
// Depends on tbrl_pkg and token_bucket_rate_limiter_unit.
module tbrl_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input tbrl_pkg::rsp_payload_type rsp_payload
);

   // Reset empties the result register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // The store is being cleared just after reset, so requests are held off
   assert property (@(posedge clock) reset |=> req_stall)
      else $error("request taken during the clearing pass");

   // A denied request never reports tokens
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.allowed) |-> (rsp_payload.remaining == '0))
      else $error("denied result with non-zero remaining");

   // A stalled result stays in place
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled result changed");

endmodule

bind token_bucket_rate_limiter_unit tbrl_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
